>>> design/slfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfo_pkg
// Shared types and constants for the stereo linear fade-out block.
// ----------------------------------------------------------------------------
package slfo_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 31;
    localparam int CNT_W    = 32;
    localparam int PROD_W   = SAMPLE_W + LEN_W;
    localparam int STEP_W   = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

    localparam logic [LEN_W-1:0] PLAY_RESET = 31'd7497000;
    localparam logic [LEN_W-1:0] FADE_RESET = 31'd441000;

    localparam logic REG_PLAY_LENGTH = 1'b0;
    localparam logic REG_FADE_LENGTH = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sample_pair_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_pair;
    } result_t;

    typedef struct packed {
        logic                       fade;
        logic                       last;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [LEN_W-1:0]           gain;
    } cmd_t;

endpackage
`default_nettype wire

>>> design/stereo_linear_fade_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_linear_fade_out
// Linear fade-out gain on a stereo 16-bit sample stream.
// ----------------------------------------------------------------------------
// Pairs below play_length pass unchanged; the next fade_length pairs are
// scaled by (play_length + fade_length - count) / fade_length, truncated
// toward zero, and the final pair carries last_pair. Pairs after the end are
// accepted and dropped without a result. Each kept pair goes through the command
// queue, the back's done state and the output register; a faded pair also
// uses the back's shared multiplier and 16-step restoring divider, run once
// per channel. The front accepts requests while the command queue has room,
// and the output register holds a result while the back works on the next
// pair. Write the length registers only while the block is idle.
// ----------------------------------------------------------------------------
module stereo_linear_fade_out
    import slfo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [LEN_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sample_pair_t     in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_data
);

    logic [LEN_W-1:0] play_length_reg;
    logic [LEN_W-1:0] fade_length_reg;
    logic             queue_full;
    logic             push;
    cmd_t             push_data;
    logic             cmd_pop;
    logic             cmd_valid;
    cmd_t             cmd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_length_reg <= PLAY_RESET;
            fade_length_reg <= FADE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLAY_LENGTH: play_length_reg <= cfg_data;
                REG_FADE_LENGTH: fade_length_reg <= cfg_data;
                default:         play_length_reg <= play_length_reg;
            endcase
        end
    end

    slfo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .play_length (play_length_reg),
        .fade_length (fade_length_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    slfo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .pop_data  (cmd_data)
    );

    slfo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fade_length (fade_length_reg),
        .cmd_valid   (cmd_valid),
        .cmd_data    (cmd_data),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

>>> design/slfo_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfo_front
// Counts accepted pairs, drops pairs past the end of the stream and turns
// the rest into pass or fade commands with their gain and last mark.
// ----------------------------------------------------------------------------
module slfo_front
    import slfo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [LEN_W-1:0] play_length,
    input  wire logic [LEN_W-1:0] fade_length,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire sample_pair_t in_data,
    input  wire logic         queue_full,
    output logic              push,
    output cmd_t              push_data
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] gain_full;
    logic             finished;
    logic             accept;

    assign total     = CNT_W'(play_length) + CNT_W'(fade_length);
    assign finished  = count_reg >= total;
    assign gain_full = total - count_reg;
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && !finished;

    always_comb
    begin
        push_data.fade  = count_reg >= CNT_W'(play_length);
        push_data.last  = (count_reg + CNT_W'(1)) == total;
        push_data.left  = in_data.left_in;
        push_data.right = in_data.right_in;
        push_data.gain  = gain_full[LEN_W-1:0];
        count_next      = push ? count_reg + CNT_W'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/slfo_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfo_queue
// Small command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module slfo_queue
    import slfo_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign full      = fill_reg == FILL_W'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> design/slfo_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfo_back
// Executes commands: passes samples through or scales each channel by
// gain / fade_length with one multiply and a 16-step restoring divider,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module slfo_back
    import slfo_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LEN_W-1:0] fade_length,
    input  wire logic             cmd_valid,
    input  wire cmd_t             cmd_data,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic                ch_reg;
    logic                ch_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [SAMPLE_W-1:0] quo_next;
    logic [SAMPLE_W-1:0] left_res_reg;
    logic [SAMPLE_W-1:0] left_res_next;
    logic [SAMPLE_W-1:0] right_res_reg;
    logic [SAMPLE_W-1:0] right_res_next;
    result_t             out_data_reg;
    result_t             out_data_next;

    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] mag;
    logic [PROD_W-1:0]   prod;
    logic [LEN_W:0]      trial;
    logic [LEN_W:0]      diff;
    logic                ge;
    logic [SAMPLE_W-1:0] quo_new;
    logic [SAMPLE_W-1:0] signed_res;
    logic                load;

    assign sample     = ch_reg ? cmd_reg.right : cmd_reg.left;
    assign mag        = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : sample;
    assign prod       = PROD_W'(mag) * PROD_W'(cmd_reg.gain);
    assign trial      = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign ge         = trial >= {1'b0, fade_length};
    assign diff       = trial - {1'b0, fade_length};
    assign quo_new    = {quo_reg[SAMPLE_W-2:0], ge};
    assign signed_res = sample[SAMPLE_W-1] ? SAMPLE_W'(-quo_new) : quo_new;
    assign load       = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        left_res_next  = left_res_reg;
        right_res_next = right_res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next       = cmd_data;
                    ch_next        = 1'b0;
                    left_res_next  = cmd_data.left;
                    right_res_next = cmd_data.right;
                    state_next     = cmd_data.fade ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                rem_next   = prod[PROD_W-1:SAMPLE_W];
                quo_next   = prod[SAMPLE_W-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                quo_next  = quo_new;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    if (ch_reg)
                    begin
                        right_res_next = signed_res;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        left_res_next = signed_res;
                        ch_next       = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_data_next.left_out  = left_res_reg;
                    out_data_next.right_out = right_res_reg;
                    out_data_next.last_pair = cmd_reg.last;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        step_reg      <= step_next;
        cmd_reg       <= cmd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        left_res_reg  <= left_res_next;
        right_res_reg <= right_res_next;
        out_data_reg  <= out_data_next;
    end

endmodule
`default_nettype wire

>>> dv/stereo_linear_fade_out_test.sv
// ----------------------------------------------------------------------------
// stereo_linear_fade_out_test
// Self-checking bench for the stereo linear fade-out block.
// ----------------------------------------------------------------------------
// A scripted run of sample pairs and length settings covers the extremes of
// both channels and both lengths. It also covers the pass, fade, zero-fade,
// zero-length and end-of-stream cases, and a shortening of the lengths below
// the pair count. Random phases follow. Each phase sets new lengths around
// the current pair count and plays the stream out with random content. Every
// accepted request is run through a bit-accurate gain model. Every result is
// compared field by field in order. Both sides pause at random, and the
// receiver holds off twice for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module stereo_linear_fade_out_test;
    import slfo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PAIRS  = 650;
    localparam int MAX_REPORTS   = 10;

    localparam logic [LEN_W-1:0] MAX_LEN = 31'h7FFF_FFFF;

    typedef enum logic {ROW_PAIR, ROW_LENGTHS} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [LEN_W-1:0] play;
        logic [LEN_W-1:0] fade;
        sample_pair_t     pair;
        logic             typed;
        logic             has_result;
        result_t          result;
    } script_row_t;

    localparam script_row_t SCRIPT [24] = '{
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd32767, -16'sd32768}, 1'b1, 1'b1,
          '{16'sd32767, -16'sd32768, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd32768, 16'sd32767}, 1'b1, 1'b1,
          '{-16'sd32768, 16'sd32767, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd0, -16'sd1}, 1'b1, 1'b1,
          '{16'sd0, -16'sd1, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd1234, -16'sd4321}, 1'b0, 1'b0, '0},
        '{ROW_LENGTHS, 31'd4, MAX_LEN, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd32768, 16'sd32767}, 1'b1, 1'b1,
          '{-16'sd32768, 16'sd32767, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd32767, -16'sd32768}, 1'b1, 1'b1,
          '{16'sd32766, -16'sd32767, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd20000, -16'sd15}, 1'b0, 1'b0, '0},
        '{ROW_LENGTHS, 31'd9, 31'd0, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd1, -16'sd1}, 1'b1, 1'b1,
          '{16'sd1, -16'sd1, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd100, -16'sd100}, 1'b1, 1'b1,
          '{16'sd100, -16'sd100, 1'b1}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd5, 16'sd5}, 1'b1, 1'b0, '0},
        '{ROW_LENGTHS, 31'd0, 31'd0, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd7, -16'sd7}, 1'b1, 1'b0, '0},
        '{ROW_LENGTHS, 31'd9, 31'd4, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd32768, 16'sd32767}, 1'b1, 1'b1,
          '{-16'sd32768, 16'sd32767, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd32768, 16'sd32767}, 1'b1, 1'b1,
          '{-16'sd24576, 16'sd24575, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd1, 16'sd1}, 1'b1, 1'b1,
          '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd32767, -16'sd32767}, 1'b1, 1'b1,
          '{16'sd8191, -16'sd8191, 1'b1}},
        '{ROW_LENGTHS, 31'd5, 31'd3, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd11, 16'sd22}, 1'b1, 1'b0, '0},
        '{ROW_LENGTHS, MAX_LEN, MAX_LEN, '0, 1'b0, 1'b0, '0},
        '{ROW_PAIR, 31'd0, 31'd0, '{16'sd123, -16'sd456}, 1'b1, 1'b1,
          '{16'sd123, -16'sd456, 1'b0}},
        '{ROW_PAIR, 31'd0, 31'd0, '{-16'sd9999, 16'sd31000}, 1'b0, 1'b0, '0}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [LEN_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    sample_pair_t     in_data;
    logic             out_valid;
    logic             out_ready;
    result_t          out_data;

    logic [LEN_W-1:0] play_len;
    logic [LEN_W-1:0] fade_len;
    logic [CNT_W-1:0] pairs_done;

    result_t pending_results [$];

    bit sender_burst;
    int pairs_sent;
    int pairs_dropped;
    int pairs_faded;
    int results_predicted;
    int results_checked;
    int settings_tried;
    int mismatches;
    int quiet_cycles;

    stereo_linear_fade_out dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit predict_pair(input sample_pair_t pair, output result_t res);
        longint unsigned total;
        longint          gain;
        longint          lq;
        longint          rq;
        total = longint'(play_len) + longint'(fade_len);
        res   = '0;
        if (pairs_done >= total)
            return 1'b0;
        if (pairs_done < play_len)
        begin
            res.left_out  = pair.left_in;
            res.right_out = pair.right_in;
        end
        else
        begin
            gain = longint'(total - pairs_done);
            lq   = longint'(pair.left_in) * gain / longint'(fade_len);
            rq   = longint'(pair.right_in) * gain / longint'(fade_len);
            res.left_out  = lq[SAMPLE_W-1:0];
            res.right_out = rq[SAMPLE_W-1:0];
            pairs_faded++;
        end
        res.last_pair = (longint'(pairs_done) + 1 == total);
        pairs_done++;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(0, 9) != 0)
            return SAMPLE_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // drain the pipeline, then let any dropped request work its way out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_lengths(input logic [LEN_W-1:0] play, input logic [LEN_W-1:0] fade,
                                 input bit fade_first);
        cfg_we    <= 1'b1;
        cfg_index <= fade_first ? REG_FADE_LENGTH : REG_PLAY_LENGTH;
        cfg_data  <= fade_first ? fade : play;
        @(posedge clk);
        cfg_index <= fade_first ? REG_PLAY_LENGTH : REG_FADE_LENGTH;
        cfg_data  <= fade_first ? play : fade;
        @(posedge clk);
        cfg_we   <= 1'b0;
        play_len = play;
        fade_len = fade;
        settings_tried++;
    endtask

    task automatic send_pair(input sample_pair_t pair, input bit typed, input bit typed_has,
                             input result_t typed_result);
        int      gap;
        bit      has_result;
        result_t res;
        gap = sender_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pair;
        do
            @(posedge clk);
        while (!in_ready);
        pairs_sent++;
        has_result = predict_pair(pair, res);
        if (typed)
        begin
            has_result = typed_has;
            res        = typed_result;
        end
        if (has_result)
        begin
            pending_results.push_back(res);
            results_predicted++;
        end
        else
            pairs_dropped++;
    endtask

    initial
    begin
        int               goal;
        int               n;
        logic [CNT_W-1:0] c;
        logic [LEN_W-1:0] play;
        logic [LEN_W-1:0] fade;
        longint unsigned  span;
        sample_pair_t     pair;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_PLAY_LENGTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        play_len   = PLAY_RESET;
        fade_len   = FADE_RESET;
        pairs_done = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_LENGTHS)
            begin
                settle();
                write_lengths(SCRIPT[i].play, SCRIPT[i].fade, i % 2 == 1);
            end
            else
                send_pair(SCRIPT[i].pair, SCRIPT[i].typed, SCRIPT[i].has_result,
                          SCRIPT[i].result);
        end

        goal = results_predicted + RANDOM_PAIRS;
        while (results_predicted < goal)
        begin
            settle();
            c = pairs_done;
            case ($urandom_range(0, 15))
                0:
                begin
                    play = LEN_W'(c + $urandom_range(1, 30));
                    fade = '0;
                end
                1:
                begin
                    play = '0;
                    fade = LEN_W'(c + $urandom_range(1, 40));
                end
                2:
                begin
                    play = LEN_W'($urandom_range(0, c));
                    fade = LEN_W'(c - play);
                end
                3:
                begin
                    play = '0;
                    fade = '0;
                end
                4:
                begin
                    play = LEN_W'(c);
                    fade = LEN_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                end
                5:
                begin
                    play = MAX_LEN;
                    fade = LEN_W'($urandom_range(0, 32'h7FFF_FFFF));
                end
                default:
                begin
                    play = LEN_W'(c + $urandom_range(0, 20));
                    fade = LEN_W'($urandom_range(1, 40));
                end
            endcase
            write_lengths(play, fade, $urandom_range(0, 1));
            span = longint'(play) + longint'(fade);
            span = (span > c) ? span - c : 0;
            n = (span > 40) ? $urandom_range(5, 20) : int'(span) + $urandom_range(0, 2);
            if (n == 0)
                n = $urandom_range(1, 3);
            sender_burst = ($urandom_range(0, 3) == 0);
            repeat (n)
            begin
                pair.left_in  = pick_sample();
                pair.right_in = pick_sample();
                send_pair(pair, 1'b0, 1'b0, '0);
            end
        end

        settle();
        $display("Summary: %0d pairs sent over %0d length settings, %0d dropped past the end",
                 pairs_sent, settings_tried, pairs_dropped);
        $display("Summary: %0d results checked, %0d faded pairs, %0d mismatches",
                 results_checked, pairs_faded, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int gap;
        int taken;
        taken = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // hold off long enough to back up the input side
            if (taken == 100 || taken == 350)
                gap = HOLD_CYCLES;
            else if ((taken / 40) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result: left %0d right %0d last %0b",
                                     out_data.left_out, out_data.right_out,
                                     out_data.last_pair));
            else
            begin
                want = pending_results.pop_front();
                if (out_data.left_out !== want.left_out
                    || out_data.right_out !== want.right_out
                    || out_data.last_pair !== want.last_pair)
                    flag_error($sformatf({"result mismatch: expected left %0d right %0d ",
                                          "last %0b, got left %0d right %0d last %0b"},
                                         want.left_out, want.right_out, want.last_pair,
                                         out_data.left_out, out_data.right_out,
                                         out_data.last_pair));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
